@@ hdl/mt19937_generator_macros.svh @@
// ---------------------------------------------------------------------------
// mt19937 generator assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef MT19937_GENERATOR_MACROS_SVH
`define MT19937_GENERATOR_MACROS_SVH

// same-cycle implication under active-low reset
`define MTG_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mt19937 generator assertion failed");

// next-cycle implication under active-low reset
`define MTG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mt19937 generator assertion failed");

`endif

@@ hdl/mtg_pkg.sv @@
// ---------------------------------------------------------------------------
// mtg_pkg
// constants, types and word functions of the mt19937 generator
// ---------------------------------------------------------------------------
package mtg_pkg;

    localparam int unsigned STATE_LEN = 624;
    localparam int unsigned MID_OFS   = 397;
    localparam int unsigned ADDR_W    = $clog2(STATE_LEN);
    localparam int unsigned WORD_W    = 32;

    localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;
    localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(STATE_LEN - 1);
    localparam logic [ADDR_W-1:0] MID_IDX   = ADDR_W'(MID_OFS);
    localparam logic [ADDR_W-1:0] WRAP_IDX  = ADDR_W'(STATE_LEN - MID_OFS);

    typedef enum logic {
        REQ_SEED = 1'b0,
        REQ_DRAW = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_CALC
    } state_t;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
        word_t mix;
        word_t v;
        mix = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
        v   = far ^ (mix >> 1);
        if (mix[0])
        begin
            v = v ^ MATRIX_A;
        end
        return v;
    endfunction

    function automatic word_t temper_word(word_t w);
        word_t t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

@@ hdl/mtg_state_ram.sv @@
// ---------------------------------------------------------------------------
// mtg_state_ram
// state table: one write port, two registered read ports
// ---------------------------------------------------------------------------
module mtg_state_ram (
    input  logic           clk,
    input  logic           we,
    input  mtg_pkg::addr_t waddr,
    input  mtg_pkg::word_t wdata,
    input  logic           re,
    input  mtg_pkg::addr_t raddr_a,
    input  mtg_pkg::addr_t raddr_b,
    output mtg_pkg::word_t rdata_a,
    output mtg_pkg::word_t rdata_b
);

    mtg_pkg::word_t mem [mtg_pkg::STATE_LEN];
    mtg_pkg::word_t rd_a_reg;
    mtg_pkg::word_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

@@ hdl/mt19937_generator.sv @@
// a draw is accepted in idle, reads both ram ports, then twists and tempers into the
// output register, waiting there while the output word waits; no new request is taken
// until then. a seed writes one table word a cycle through the seed multiplier
// draws twist one table word on the fly: a read on both ram ports, then a step that
// twists, writes back and tempers; an unseeded draw gives a zero word, not_seeded set
// reset: no word pending, unseeded; the table is not cleared
// ---------------------------------------------------------------------------
// mt19937_generator
// 32-bit mersenne twister with seed and draw requests
// ---------------------------------------------------------------------------
module mt19937_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // seed
    input  logic [0:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // random_word
    output logic [0:0]  m_axis_tuser    // not_seeded
);

    mtg_pkg::state_t state_reg, state_next;
    mtg_pkg::addr_t  pos_reg, pos_next;
    mtg_pkg::addr_t  cnt_reg, cnt_next;
    mtg_pkg::word_t  prev_reg, prev_next;
    mtg_pkg::word_t  cur_reg, cur_next;
    logic            seeded_reg, seeded_next;
    logic            out_valid_reg, out_valid_next;
    mtg_pkg::word_t  out_word_reg, out_word_next;
    logic            out_flag_reg, out_flag_next;

    logic            ram_we;
    mtg_pkg::addr_t  ram_waddr;
    mtg_pkg::word_t  ram_wdata;
    logic            ram_re;
    mtg_pkg::addr_t  nxt_idx;
    mtg_pkg::addr_t  far_idx;
    mtg_pkg::word_t  rd_nxt;
    mtg_pkg::word_t  rd_far;
    mtg_pkg::word_t  seed_mix;
    mtg_pkg::word_t  seed_val;
    mtg_pkg::word_t  new_word;
    logic            slot_free;

    assign nxt_idx = (pos_reg == mtg_pkg::LAST_IDX) ? '0 : pos_reg + 1'b1;
    assign far_idx = (pos_reg < mtg_pkg::WRAP_IDX) ? pos_reg + mtg_pkg::MID_IDX
                                                   : pos_reg - mtg_pkg::WRAP_IDX;

    assign seed_mix  = prev_reg ^ (prev_reg >> 30);
    assign seed_val  = mtg_pkg::word_t'(mtg_pkg::INIT_MULT * seed_mix)
                     + mtg_pkg::word_t'(cnt_reg);
    assign new_word  = mtg_pkg::twist_word(cur_reg, rd_nxt, rd_far);
    assign slot_free = !out_valid_reg || m_axis_tready;

    mtg_state_ram u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (nxt_idx),
        .raddr_b (far_idx),
        .rdata_a (rd_nxt),
        .rdata_b (rd_far)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtg_pkg::ST_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        out_word_reg <= out_word_next;
        out_flag_reg <= out_flag_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_word_next  = out_word_reg;
        out_flag_next  = out_flag_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = new_word;
        ram_re         = 1'b0;
        s_axis_tready  = 1'b0;

        case (state_reg)
            mtg_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser[0] == mtg_pkg::REQ_SEED)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = '0;
                        ram_wdata   = s_axis_tdata;
                        prev_next   = s_axis_tdata;
                        cur_next    = s_axis_tdata;
                        cnt_next    = mtg_pkg::addr_t'(1);
                        seeded_next = 1'b1;
                        state_next  = mtg_pkg::ST_SEED;
                    end
                    else
                    begin
                        state_next = mtg_pkg::ST_READ;
                    end
                end
            end
            mtg_pkg::ST_SEED:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = seed_val;
                prev_next = seed_val;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == mtg_pkg::LAST_IDX)
                begin
                    pos_next   = '0;
                    state_next = mtg_pkg::ST_IDLE;
                end
            end
            mtg_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = mtg_pkg::ST_CALC;
            end
            mtg_pkg::ST_CALC:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = mtg_pkg::ST_IDLE;
                    if (seeded_reg)
                    begin
                        ram_we        = 1'b1;
                        cur_next      = rd_nxt;
                        pos_next      = nxt_idx;
                        out_word_next = mtg_pkg::temper_word(new_word);
                        out_flag_next = 1'b0;
                    end
                    else
                    begin
                        out_word_next = '0;
                        out_flag_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = mtg_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;
    assign m_axis_tuser  = out_flag_reg;

endmodule

@@ hdl/mtg_checker.sv @@
// ---------------------------------------------------------------------------
// mtg_checker
// port-level checks of the mt19937 generator, bound to the top level
// ---------------------------------------------------------------------------
`include "mt19937_generator_macros.svh"

module mtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                  && (s_axis_tuser == s_axis_tuser);

    // a stalled word holds
    `MTG_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // an unseeded draw gives a zero word
    `MTG_ASSERT_IMPLY(a_unseeded_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'd0)

    // one request at a time
    `MTG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_fire, !s_axis_tready)

    // a new word only follows a busy cycle
    `MTG_ASSERT_IMPLY(a_word_after_work, clk, rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind mt19937_generator mtg_checker u_checker (.*);

@@ tb/mt19937_generator_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mt19937_generator_test
// Drives seed and draw words into the generator and checks every output word
// against a Mersenne Twister kept inside the bench: its own table, position
// and seeded flag. Covers draws before any seed, seeds at the extremes,
// reseeding mid-stream and back to back, long draw runs that twist the table
// more than once, and random mixes. Both sides stall at random.
// ---------------------------------------------------------------------------
module mt19937_generator_test;

    typedef struct {
        mtg_pkg::word_t random_word;
        logic           not_seeded;
    } draw_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // seed
    logic [0:0]  s_axis_tuser = '0;    // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // random_word
    logic [0:0]  m_axis_tuser;         // not_seeded

    mtg_pkg::word_t mt_table [mtg_pkg::STATE_LEN];
    int unsigned    mt_pos = mtg_pkg::STATE_LEN;
    bit             mt_seeded = 1'b0;
    draw_result_t   expected_draws [$];

    bit          idle_en = 1'b1;
    int          stall_left = 0;
    int          error_count = 0;
    int          words_checked = 0;
    int          seeds_sent = 0;
    int          draws_sent = 0;
    int          unseeded_draws = 0;
    int          twist_count = 0;

    mt19937_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // twister state update for one accepted word
    task automatic advance_twister(input mtg_pkg::req_t req, input mtg_pkg::word_t seed_val);
        mtg_pkg::word_t prev;
        mtg_pkg::word_t mix;
        mtg_pkg::word_t v;
        mtg_pkg::word_t w;
        draw_result_t   r;
        if (req == mtg_pkg::REQ_SEED)
        begin
            mt_table[0] = seed_val;
            for (int k = 1; k < mtg_pkg::STATE_LEN; k++)
            begin
                prev        = mt_table[k-1];
                mt_table[k] = mtg_pkg::INIT_MULT * (prev ^ (prev >> 30))
                            + mtg_pkg::word_t'(k);
            end
            mt_pos    = mtg_pkg::STATE_LEN;
            mt_seeded = 1'b1;
            seeds_sent++;
            return;
        end
        draws_sent++;
        if (!mt_seeded)
        begin
            r.random_word = '0;
            r.not_seeded  = 1'b1;
            unseeded_draws++;
            expected_draws.push_back(r);
            return;
        end
        if (mt_pos >= mtg_pkg::STATE_LEN)
        begin
            for (int k = 0; k < mtg_pkg::STATE_LEN; k++)
            begin
                mix = (mt_table[k] & mtg_pkg::UPPER_MASK)
                    | (mt_table[(k + 1) % mtg_pkg::STATE_LEN] & mtg_pkg::LOWER_MASK);
                v   = mt_table[(k + mtg_pkg::MID_OFS) % mtg_pkg::STATE_LEN] ^ (mix >> 1);
                if (mix[0])
                begin
                    v = v ^ mtg_pkg::MATRIX_A;
                end
                mt_table[k] = v;
            end
            mt_pos = 0;
            twist_count++;
        end
        w = mt_table[mt_pos];
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & mtg_pkg::TEMPER_B);
        w = w ^ ((w << 15) & mtg_pkg::TEMPER_C);
        w = w ^ (w >> 18);
        r.random_word = w;
        r.not_seeded  = 1'b0;
        expected_draws.push_back(r);
        mt_pos = (mt_pos + 1) & 10'h3ff;
    endtask

    task automatic send_word(input mtg_pkg::req_t req, input mtg_pkg::word_t seed_val);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seed_val;
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        advance_twister(req, seed_val);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_draws.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic mtg_pkg::word_t pick_seed();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_unseeded_draws();
        send_word(mtg_pkg::REQ_DRAW, 32'h0000_0000);
        send_word(mtg_pkg::REQ_DRAW, 32'hffff_ffff);
        send_word(mtg_pkg::REQ_DRAW, $urandom());
    endtask

    task automatic test_seed_extremes();
        mtg_pkg::word_t seeds [3];
        seeds = '{32'h0000_0000, 32'hffff_ffff, 32'd5489};
        foreach (seeds[i])
        begin
            send_word(mtg_pkg::REQ_SEED, seeds[i]);
            repeat (4) send_word(mtg_pkg::REQ_DRAW, pick_seed());
        end
        // back to back seeds, the second one wins
        send_word(mtg_pkg::REQ_SEED, $urandom());
        send_word(mtg_pkg::REQ_SEED, $urandom());
        send_word(mtg_pkg::REQ_DRAW, $urandom());
    endtask

    task automatic test_long_run();
        send_word(mtg_pkg::REQ_SEED, $urandom());
        for (int i = 0; i < 700; i++)
        begin
            if (i == 300)
            begin
                wait_for_drain();
            end
            send_word(mtg_pkg::REQ_DRAW, pick_seed());
        end
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_word(mtg_pkg::REQ_SEED, pick_seed());
            end
            else
            begin
                send_word(mtg_pkg::REQ_DRAW, pick_seed());
            end
        end
    endtask

    // output side stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_words
        draw_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_draws.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("unexpected word: random_word=%h not_seeded=%b",
                             m_axis_tdata, m_axis_tuser);
                end
            end
            else
            begin
                want = expected_draws.pop_front();
                words_checked++;
                if (m_axis_tdata !== want.random_word || m_axis_tuser !== want.not_seeded)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("mismatch on word %0d: expected %h/%b, got %h/%b",
                                 words_checked, want.random_word, want.not_seeded,
                                 m_axis_tdata, m_axis_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unseeded_draws();
        test_seed_extremes();
        test_long_run();
        test_random_mix(150);
        idle_en = 1'b0;
        test_random_mix(80);
        wait_for_drain();
        repeat (20) @(posedge clk);
        $display("covered %0d seeds and %0d draws (%0d before any seed), %0d table twists",
                 seeds_sent, draws_sent, unseeded_draws, twist_count);
        $display("%0d output words checked, %0d mismatches", words_checked, error_count);
        if (error_count == 0 && expected_draws.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ mt19937_generator.f @@
+incdir+hdl
hdl/mtg_pkg.sv
hdl/mtg_state_ram.sv
hdl/mt19937_generator.sv
hdl/mtg_checker.sv
tb/mt19937_generator_test.sv
